>>> rtl/integer_to_padded_text_top_assert.svh
// Assertion macros for the integer to padded text block
`ifndef INTEGER_TO_PADDED_TEXT_TOP_ASSERT_SVH
`define INTEGER_TO_PADDED_TEXT_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent
`define ITPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent
`define ITPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/itpt_pkg.sv
// Shared types, codes and character helpers for the integer to padded text block
`default_nettype none

package itpt_pkg;

	localparam int VAL_W       = 32;
	localparam int MAX_RESULTS = 64;
	localparam int DIV_STEP    = 8;

	localparam logic [7:0] ATTR_RESET = 8'd7;

	localparam logic [5:0] RADIX_MIN  = 6'd2;
	localparam logic [5:0] RADIX_MAX  = 6'd36;
	localparam logic [5:0] RADIX_OCT  = 6'd8;
	localparam logic [5:0] RADIX_HEX  = 6'd16;
	localparam logic [5:0] NUM_DIGITS = 6'd36;

	localparam int FLAG_ZPAD  = 0;
	localparam int FLAG_LEFT  = 1;
	localparam int FLAG_ALT   = 2;
	localparam int FLAG_LOWER = 3;

	localparam logic [1:0] SIGN_NONE  = 2'd0;
	localparam logic [1:0] SIGN_PLUS  = 2'd1;
	localparam logic [1:0] SIGN_SPACE = 2'd2;
	localparam logic [1:0] SIGN_MINUS = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	typedef struct packed {
		logic [31:0] value;
		logic [5:0]  radix;
		logic [5:0]  min_width;
		logic [5:0]  min_digits;
		logic [3:0]  format_flags;
		logic [1:0]  sign_mode;
	} in_item_t;

	typedef struct packed {
		logic [7:0] character;
		logic [7:0] attribute;
		logic       last;
		logic       bad_radix;
	} out_item_t;

	typedef enum logic [3:0] {
		KIND_LEAD  = 4'd0,
		KIND_SIGN  = 4'd1,
		KIND_PFX0  = 4'd2,
		KIND_PFXX  = 4'd3,
		KIND_ZPAD  = 4'd4,
		KIND_PZERO = 4'd5,
		KIND_DIGIT = 4'd6,
		KIND_TRAIL = 4'd7,
		KIND_ERR   = 4'd8
	} char_kind_t;

	typedef struct packed {
		logic       load;
		logic       div;
		logic       setup;
		logic       emit;
		char_kind_t kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic radix_bad;
		logic div_done;
		logic slot_free;
		logic pad_zero;
		logic pz_zero;
		logic idx_zero;
		logic use_lead;
		logic use_zpad;
		logic use_trail;
		logic has_sign;
		logic pfx8;
		logic pfx16;
		logic cap;
	} dp_status_t;

	// Map a digit value to its ASCII character in the chosen case
	function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
		logic [5:0] m;
		m = (d >= NUM_DIGITS) ? d - NUM_DIGITS : d;
		if (m < 6'd10) begin
			return CH_ZERO + {2'b00, m};
		end
		return (lower ? CH_A_LO : CH_A_UP) + {2'b00, m} - 8'd10;
	endfunction

endpackage

`default_nettype wire

>>> rtl/itpt_ctrl.sv
// Sequencer for the integer to padded text block: divide, plan, then emit each segment
`default_nettype none

module itpt_ctrl import itpt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t st,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_ERR   = 12'b000000000010,
		S_DIV   = 12'b000000000100,
		S_SETUP = 12'b000000001000,
		S_LEAD  = 12'b000000010000,
		S_SIGN  = 12'b000000100000,
		S_PFX0  = 12'b000001000000,
		S_PFXX  = 12'b000010000000,
		S_ZPAD  = 12'b000100000000,
		S_PZERO = 12'b001000000000,
		S_DIGIT = 12'b010000000000,
		S_TRAIL = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd.load  = 1'b0;
		cmd.div   = 1'b0;
		cmd.setup = 1'b0;
		cmd.emit  = 1'b0;
		cmd.kind  = KIND_LEAD;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = st.radix_bad ? S_ERR : S_DIV;
				end
			end
			S_ERR: begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_ERR;
				if (st.slot_free) begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (st.div_done) begin
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_LEAD;
			end
			S_LEAD: begin
				if (st.use_lead && !st.pad_zero) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_LEAD;
					if (st.slot_free && st.cap) begin
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_SIGN;
				end
			end
			S_SIGN: begin
				if (st.has_sign) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_SIGN;
					if (st.slot_free) begin
						state_d = st.cap ? S_IDLE : S_PFX0;
					end
				end else begin
					state_d = S_PFX0;
				end
			end
			S_PFX0: begin
				if (st.pfx8 || st.pfx16) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_PFX0;
					if (st.slot_free) begin
						state_d = st.cap ? S_IDLE : S_PFXX;
					end
				end else begin
					state_d = S_PFXX;
				end
			end
			S_PFXX: begin
				if (st.pfx16) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_PFXX;
					if (st.slot_free) begin
						state_d = st.cap ? S_IDLE : S_ZPAD;
					end
				end else begin
					state_d = S_ZPAD;
				end
			end
			S_ZPAD: begin
				if (st.use_zpad && !st.pad_zero) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_ZPAD;
					if (st.slot_free && st.cap) begin
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_PZERO;
				end
			end
			S_PZERO: begin
				if (!st.pz_zero) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_PZERO;
					if (st.slot_free && st.cap) begin
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_DIGIT;
				end
			end
			S_DIGIT: begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_DIGIT;
				if (st.slot_free) begin
					if (st.cap) begin
						state_d = S_IDLE;
					end else if (st.idx_zero) begin
						state_d = S_TRAIL;
					end
				end
			end
			S_TRAIL: begin
				if (st.use_trail && !st.pad_zero) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_TRAIL;
					if (st.slot_free && st.cap) begin
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/itpt_datapath.sv
// Datapath: item capture, digit divider, digit memory, segment counters, output register
`default_nettype none

module itpt_datapath import itpt_pkg::*; #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_FIELD  = 60
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire in_item_t   in_data,
	input  wire logic       out_ready,
	output logic            out_valid,
	output out_item_t       out_data,
	input  wire ctrl_cmd_t  cmd,
	output dp_status_t      st
);

	localparam int DIV_W  = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
	localparam int PASSES = DIV_W / DIV_STEP;
	localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;
	localparam int AW     = $clog2(VALUE_BITS);
	localparam int CW     = $clog2(VALUE_BITS + 1);
	localparam int CP     = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;

	logic [7:0]       attr_q;
	logic [5:0]       radix_q, fw_q, md_q;
	logic [3:0]       flags_q;
	logic [1:0]       smode_q;
	logic [DIV_W-1:0] work_q, work_d, v_ext;
	logic [5:0]       rem_q, rem_d;
	logic [PW-1:0]    pc_q;
	logic [CW-1:0]    nd_q;
	logic [AW-1:0]    idx_q, idx_d;
	logic [5:0]       pad_q, pz_q, pad_set, pz_set;
	logic [5:0]       cnt_q;
	logic [5:0]       rd_q;
	logic [5:0]       mem [VALUE_BITS];
	logic             out_valid_q;
	out_item_t        out_q;

	logic [DIV_STEP-1:0] top_bits, qbits;
	logic [5:0]          r;
	logic [6:0]          t;
	logic                last_pass, nd_full, fire, lower;
	logic [5:0]          wid, prc;
	logic [7:0]          nd8, prc8, dig_tot, sub;
	logic signed [8:0]   size_s;
	logic [7:0]          ch;
	logic                last;

	assign v_ext = DIV_W'(in_data.value[CP-1:0]);
	assign lower = flags_q[FLAG_LOWER];

	// Eight restoring steps per cycle on the narrow remainder
	always_comb begin
		top_bits = work_q[DIV_W-1 -: DIV_STEP];
		r        = rem_q;
		qbits    = '0;
		t        = '0;
		for (int i = DIV_STEP - 1; i >= 0; i--) begin
			t = {r, top_bits[i]};
			if (t >= {1'b0, radix_q}) begin
				t        = t - {1'b0, radix_q};
				qbits[i] = 1'b1;
			end
			r = t[5:0];
		end
		rem_d  = r;
		work_d = (work_q << DIV_STEP) | DIV_W'(qbits);
	end

	assign last_pass = (pc_q == PW'(PASSES - 1));
	assign nd_full   = (nd_q == CW'(VALUE_BITS - 1));

	// Segment plan from the captured fields and the digit count
	always_comb begin
		wid     = (fw_q > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : fw_q;
		prc     = (md_q > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : md_q;
		nd8     = 8'(nd_q);
		prc8    = {2'b00, prc};
		dig_tot = (nd8 > prc8) ? nd8 : prc8;
		sub     = 8'(st.has_sign) + (st.pfx16 ? 8'd2 : (st.pfx8 ? 8'd1 : 8'd0)) + dig_tot;
		size_s  = $signed({3'b000, wid}) - $signed({1'b0, sub});
		pad_set = (size_s > 9'sd0) ? size_s[5:0] : '0;
		pz_set  = (prc8 > nd8) ? 6'(prc8 - nd8) : '0;
	end

	assign st.radix_bad = (in_data.radix < RADIX_MIN) || (in_data.radix > RADIX_MAX);
	assign st.div_done  = last_pass && ((work_d == '0) || nd_full);
	assign st.slot_free = !out_valid_q || out_ready;
	assign st.pad_zero  = (pad_q == '0);
	assign st.pz_zero   = (pz_q == '0);
	assign st.idx_zero  = (idx_q == '0);
	assign st.use_lead  = !flags_q[FLAG_LEFT] && !flags_q[FLAG_ZPAD];
	assign st.use_zpad  = !flags_q[FLAG_LEFT] && flags_q[FLAG_ZPAD];
	assign st.use_trail = flags_q[FLAG_LEFT];
	assign st.has_sign  = (smode_q != SIGN_NONE);
	assign st.pfx8      = flags_q[FLAG_ALT] && (radix_q == RADIX_OCT);
	assign st.pfx16     = flags_q[FLAG_ALT] && (radix_q == RADIX_HEX);
	assign st.cap       = (cnt_q == 6'(MAX_RESULTS - 1));

	assign fire = cmd.emit && st.slot_free;

	always_comb begin
		ch = CH_NUL;
		case (cmd.kind)
			KIND_LEAD, KIND_TRAIL: ch = CH_SPACE;
			KIND_SIGN: begin
				case (smode_q)
					SIGN_PLUS:  ch = CH_PLUS;
					SIGN_SPACE: ch = CH_SPACE;
					SIGN_MINUS: ch = CH_MINUS;
					default:    ch = CH_NUL;
				endcase
			end
			KIND_PFX0, KIND_ZPAD, KIND_PZERO: ch = CH_ZERO;
			KIND_PFXX:  ch = lower ? CH_X_LO : CH_X_UP;
			KIND_DIGIT: ch = digit_char(rd_q, lower);
			KIND_ERR:   ch = CH_NUL;
			default:    ch = CH_NUL;
		endcase
	end

	always_comb begin
		last = st.cap;
		case (cmd.kind)
			KIND_DIGIT: last = last || (st.idx_zero && (!st.use_trail || st.pad_zero));
			KIND_TRAIL: last = last || (pad_q == 6'd1);
			KIND_ERR:   last = 1'b1;
			default:    last = st.cap;
		endcase
	end

	// Next read address: the memory read is registered, so look one step ahead
	always_comb begin
		idx_d = idx_q;
		if (cmd.setup) begin
			idx_d = AW'(nd_q - CW'(1));
		end else if (fire && (cmd.kind == KIND_DIGIT)) begin
			idx_d = idx_q - AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radix_q <= in_data.radix;
			fw_q    <= in_data.min_width;
			md_q    <= in_data.min_digits;
			flags_q <= in_data.format_flags;
			smode_q <= in_data.sign_mode;
			work_q  <= v_ext;
			rem_q   <= '0;
		end else if (cmd.div) begin
			work_q <= work_d;
			rem_q  <= last_pass ? 6'd0 : rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			nd_q  <= '0;
			idx_q <= '0;
			pad_q <= '0;
			pz_q  <= '0;
			cnt_q <= '0;
		end else begin
			idx_q <= idx_d;
			if (cmd.load) begin
				pc_q  <= '0;
				nd_q  <= '0;
				cnt_q <= '0;
			end else if (cmd.div) begin
				if (last_pass) begin
					pc_q <= '0;
					nd_q <= nd_q + CW'(1);
				end else begin
					pc_q <= pc_q + PW'(1);
				end
			end else if (cmd.setup) begin
				pad_q <= pad_set;
				pz_q  <= pz_set;
			end else if (fire) begin
				cnt_q <= cnt_q + 6'd1;
				case (cmd.kind)
					KIND_LEAD, KIND_ZPAD, KIND_TRAIL: pad_q <= pad_q - 6'd1;
					KIND_PZERO: pz_q <= pz_q - 6'd1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div && last_pass) begin
			mem[nd_q[AW-1:0]] <= rem_d;
		end
		rd_q <= mem[idx_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.character <= ch;
			out_q.attribute <= attr_q;
			out_q.last      <= last;
			out_q.bad_radix <= (cmd.kind == KIND_ERR);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> rtl/integer_to_padded_text_top.sv
// Top level of the integer to padded text block: sequencer, datapath and checks
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_ready     in_data  (in_item_t)
//   out      source     out_valid / out_ready   out_data (out_item_t)
//   cfg      sink       cfg_wr_en               cfg_wr_data (attribute byte)
//
// After the accept cycle the divider produces each digit, eight quotient bits a cycle; then
// the block plans the segments, emits the characters, and takes a quiet step in each of the
// four pad and zero segments and in each skipped sign or prefix step. A bad base gives a
// single error result. Reset clears sequencer, counters and output valid, not the digit
// memory. A stalled output holds the current character and pauses the sequencer.
`default_nettype none
`include "integer_to_padded_text_top_assert.svh"

module integer_to_padded_text_top import itpt_pkg::*; #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_FIELD  = 60
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_item_t       out_data
);

	ctrl_cmd_t  cmd;
	dp_status_t st;

	// Sequencer: walks divide, plan and the text segments in order
	itpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Datapath: holds the item, divides, stores digits and drives each transfer
	itpt_datapath #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_FIELD  (MAX_FIELD)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.out_data    (out_data),
		.cmd         (cmd),
		.st          (st)
	);

	// A taken item keeps the input closed while its text is produced
	`ITPT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input open after accept")

	// A bad base moves straight to the error result, never into the divider
	`ITPT_ASSERT_NEXT(a_bad_radix_no_div, in_valid && in_ready && st.radix_bad, !cmd.div, "divider started on bad radix")

	// The error result is a lone NUL that closes its run
	`ITPT_ASSERT_NOW(a_error_shape, out_valid && out_data.bad_radix, out_data.last && (out_data.character == CH_NUL), "malformed error result")

	// A text run ends on a digit or a space, never on NUL
	`ITPT_ASSERT_NOW(a_last_printable, out_valid && out_data.last && !out_data.bad_radix, out_data.character != CH_NUL, "text run ends on NUL")

endmodule

`default_nettype wire

>>> sim/integer_to_padded_text_top_tb.sv
// Self-checking testbench for the integer to padded text block
`default_nettype none

module integer_to_padded_text_top_tb;
	import itpt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any transfer before the run is declared hung. The slowest
	// legitimate quiet stretch is a base 2 conversion plus the longest stall.
	localparam int IDLE_LIMIT   = 20000;
	localparam int SETTLE_TICKS = 200;
	localparam int FIELD_CAP    = 60;

	localparam logic [3:0] F_ZPAD  = 4'(1 << FLAG_ZPAD);
	localparam logic [3:0] F_LEFT  = 4'(1 << FLAG_LEFT);
	localparam logic [3:0] F_ALT   = 4'(1 << FLAG_ALT);
	localparam logic [3:0] F_LOWER = 4'(1 << FLAG_LOWER);

	localparam string UPPER_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
	localparam string LOWER_SET = "0123456789abcdefghijklmnopqrstuvwxyz";

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	in_item_t   in_data     = '0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	out_item_t  out_data;

	// Items waiting to be sent and characters waiting to be seen
	in_item_t  pending_items[$];
	out_item_t expected_chars[$];

	logic [7:0] shadow_attr = ATTR_RESET;  // our copy of the attribute register
	bit         quiet       = 1'b0;        // suppress idling on both sides
	int         send_gap    = 0;
	int         stall_left  = 0;
	int         idle_cycles = 0;
	int         error_count = 0;

	integer_to_padded_text_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gap lengths: mostly short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 15);
		if (r < 10) begin
			return $urandom_range(0, 2);
		end else if (r < 15) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(20, 70);
	endfunction

	function automatic in_item_t mk_item(input logic [31:0] v, input logic [5:0] rdx,
			input logic [5:0] fw, input logic [5:0] md, input logic [3:0] fl,
			input logic [1:0] sm);
		in_item_t it;
		it.value        = v;
		it.radix        = rdx;
		it.min_width    = fw;
		it.min_digits   = md;
		it.format_flags = fl;
		it.sign_mode    = sm;
		return it;
	endfunction

	// Width-like fields: mostly small, some anywhere, some near the top
	function automatic logic [5:0] pick_extent(input int small_max);
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			return 6'($urandom_range(0, small_max));
		end else if (r < 9) begin
			return 6'($urandom_range(0, 63));
		end
		return 6'($urandom_range(55, 63));
	endfunction

	function automatic in_item_t make_random_item();
		logic [31:0] v;
		logic [5:0]  rdx;
		int          r;
		case ($urandom_range(0, 4))
			0: begin
				v = $urandom_range(0, 255);
			end
			1: begin
				v = $urandom() >> $urandom_range(0, 31);
			end
			2: begin
				r = $urandom_range(0, 2);
				v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'h1 << $urandom_range(0, 31);
			end
			default: begin
				v = $urandom();
			end
		endcase
		// Mostly legal bases, favouring the ones with a prefix
		r = $urandom_range(0, 19);
		if (r < 3) begin
			rdx = 6'($urandom_range(0, 63));
		end else if (r < 7) begin
			rdx = RADIX_HEX;
		end else if (r < 10) begin
			rdx = RADIX_OCT;
		end else if (r < 13) begin
			rdx = 6'd10;
		end else begin
			rdx = 6'($urandom_range(RADIX_MIN, RADIX_MAX));
		end
		return mk_item(v, rdx, pick_extent(14), pick_extent(10),
				4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
	endfunction

	function automatic void add_char(ref out_item_t run[$], input logic [7:0] ch);
		out_item_t o;
		if (run.size() >= MAX_RESULTS) begin
			return;
		end
		o.character = ch;
		o.attribute = shadow_attr;
		o.last      = 1'b0;
		o.bad_radix = 1'b0;
		run.push_back(o);
	endfunction

	// Work out the text run for one accepted item and queue it up
	function automatic void format_expected(input in_item_t it);
		out_item_t   run[$];
		out_item_t   err;
		logic [31:0] v;
		logic [5:0]  digs[32];
		int          base, size, prec, nd, k;
		bit          zpad, left, alt, lower;
		logic [7:0]  sign_ch;
		base  = int'(it.radix);
		zpad  = it.format_flags[FLAG_ZPAD];
		left  = it.format_flags[FLAG_LEFT];
		alt   = it.format_flags[FLAG_ALT];
		lower = it.format_flags[FLAG_LOWER];
		if (it.radix < RADIX_MIN || it.radix > RADIX_MAX) begin
			err.character = CH_NUL;
			err.attribute = shadow_attr;
			err.last      = 1'b1;
			err.bad_radix = 1'b1;
			expected_chars.push_back(err);
			return;
		end
		size = (it.min_width > FIELD_CAP) ? FIELD_CAP : int'(it.min_width);
		prec = (it.min_digits > FIELD_CAP) ? FIELD_CAP : int'(it.min_digits);
		if (left) begin
			zpad = 1'b0;
		end
		case (it.sign_mode)
			SIGN_PLUS:  sign_ch = CH_PLUS;
			SIGN_SPACE: sign_ch = CH_SPACE;
			SIGN_MINUS: sign_ch = CH_MINUS;
			default:    sign_ch = CH_NUL;
		endcase
		// Peel off digits, least significant first
		v  = it.value;
		nd = 0;
		do begin
			digs[nd] = 6'(v % base);
			v        = v / base;
			nd++;
		end while (v != 0 && nd < 32);
		if (sign_ch != CH_NUL) begin
			size--;
		end
		if (alt) begin
			if (it.radix == RADIX_HEX) begin
				size -= 2;
			end else if (it.radix == RADIX_OCT) begin
				size -= 1;
			end
		end
		if (nd > prec) begin
			prec = nd;
		end
		size -= prec;
		if (!zpad && !left) begin
			while (size > 0) begin
				add_char(run, CH_SPACE);
				size--;
			end
		end
		if (sign_ch != CH_NUL) begin
			add_char(run, sign_ch);
		end
		if (alt && it.radix == RADIX_OCT) begin
			add_char(run, CH_ZERO);
		end else if (alt && it.radix == RADIX_HEX) begin
			add_char(run, CH_ZERO);
			add_char(run, lower ? CH_X_LO : CH_X_UP);
		end
		if (!left) begin
			while (size > 0) begin
				add_char(run, zpad ? CH_ZERO : CH_SPACE);
				size--;
			end
		end
		for (k = nd; k < prec; k++) begin
			add_char(run, CH_ZERO);
		end
		for (k = nd - 1; k >= 0; k--) begin
			add_char(run, lower ? LOWER_SET[digs[k]] : UPPER_SET[digs[k]]);
		end
		while (size > 0) begin
			add_char(run, CH_SPACE);
			size--;
		end
		run[run.size() - 1].last = 1'b1;
		foreach (run[i]) begin
			expected_chars.push_back(run[i]);
		end
	endfunction

	// Sender: predict on every accepted transfer, then load the next item after
	// its gap; hold the payload while the block is not ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				format_expected(in_data);
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0 && !quiet) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					in_data  <= pending_items.pop_front();
					in_valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check every transfer against the oldest expectation, and
	// stall now and then.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					error_count++;
					$display("%0t: unexpected character: actual char=%h attr=%h last=%b bad=%b",
							$time, out_data.character, out_data.attribute, out_data.last,
							out_data.bad_radix);
				end else begin
					want = expected_chars.pop_front();
					if (out_data.character !== want.character
							|| out_data.attribute !== want.attribute
							|| out_data.last !== want.last
							|| out_data.bad_radix !== want.bad_radix) begin
						error_count++;
						$display("%0t: mismatch: expected char=%h attr=%h last=%b bad=%b, %s%h %s%h %s%b %s%b",
								$time, want.character, want.attribute, want.last,
								want.bad_radix, "actual char=", out_data.character,
								"attr=", out_data.attribute, "last=", out_data.last,
								"bad=", out_data.bad_radix);
					end
				end
			end
			if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0 && !quiet) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: drop out if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Hold until everything sent has come back, then let the block settle
	task automatic drain_and_settle();
		while (pending_items.size() != 0 || in_valid || expected_chars.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_attr(input logic [7:0] val);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= val;
		shadow_attr = val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [7:0] attr_plan[5];
		attr_plan = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'hA5, 8'h5A};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed run at the reset attribute
		pending_items.push_back(mk_item(32'd0, 6'd10, 6'd0, 6'd0, 4'h0, SIGN_NONE));
		pending_items.push_back(mk_item(32'hFFFF_FFFF, 6'd10, 6'd0, 6'd0, 4'h0, SIGN_NONE));
		pending_items.push_back(mk_item(32'hFFFF_FFFF, RADIX_MIN, 6'd0, 6'd0, 4'h0, SIGN_NONE));
		pending_items.push_back(mk_item(32'hFFFF_FFFF, RADIX_MAX, 6'd0, 6'd0, 4'h0, SIGN_NONE));
		// Zero in hex with the prefix, both cases
		pending_items.push_back(mk_item(32'd0, RADIX_HEX, 6'd0, 6'd0, F_ALT, SIGN_NONE));
		pending_items.push_back(mk_item(32'd0, RADIX_HEX, 6'd0, 6'd0, F_ALT | F_LOWER, SIGN_NONE));
		pending_items.push_back(mk_item(32'hDEAD_BEEF, RADIX_HEX, 6'd12, 6'd0, F_ALT | F_LOWER,
				SIGN_PLUS));
		pending_items.push_back(mk_item(32'd255, RADIX_OCT, 6'd8, 6'd0, F_ALT | F_ZPAD,
				SIGN_SPACE));
		pending_items.push_back(mk_item(32'd8, RADIX_OCT, 6'd0, 6'd0, F_ALT, SIGN_NONE));
		pending_items.push_back(mk_item(32'd1234, 6'd10, 6'd10, 6'd0, F_ZPAD, SIGN_MINUS));
		// Left justification overrides zero padding
		pending_items.push_back(mk_item(32'd1234, 6'd10, 6'd10, 6'd0, F_ZPAD | F_LEFT, SIGN_PLUS));
		pending_items.push_back(mk_item(32'd42, 6'd10, 6'd8, 6'd5, F_LEFT, SIGN_NONE));
		// Width and precision beyond the cap
		pending_items.push_back(mk_item(32'd42, 6'd10, 6'd63, 6'd0, 4'h0, SIGN_NONE));
		pending_items.push_back(mk_item(32'd42, 6'd10, 6'd0, 6'd63, 4'h0, SIGN_NONE));
		pending_items.push_back(mk_item(32'd42, 6'd10, 6'd63, 6'd63, 4'hF, SIGN_MINUS));
		pending_items.push_back(mk_item(32'd1, RADIX_MIN, 6'd63, 6'd63, F_ZPAD, SIGN_PLUS));
		// Bases outside the legal range
		pending_items.push_back(mk_item(32'd7, 6'd0, 6'd5, 6'd0, 4'h0, SIGN_NONE));
		pending_items.push_back(mk_item(32'd7, 6'd1, 6'd0, 6'd3, F_ALT, SIGN_PLUS));
		pending_items.push_back(mk_item(32'd7, 6'd37, 6'd0, 6'd0, 4'h0, SIGN_NONE));
		pending_items.push_back(mk_item(32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63, 4'hF, SIGN_MINUS));
		// Prefix flag with a base that has none
		pending_items.push_back(mk_item(32'd255, 6'd10, 6'd4, 6'd0, F_ALT, SIGN_NONE));
		pending_items.push_back(mk_item(32'd12345678, RADIX_MAX, 6'd0, 6'd0, F_LOWER, SIGN_NONE));
		pending_items.push_back(mk_item(32'd0, RADIX_MIN, 6'd5, 6'd3, 4'h0, SIGN_NONE));
		pending_items.push_back(mk_item(32'hFFFF_FFFF, RADIX_HEX, 6'd0, 6'd0, F_ALT, SIGN_PLUS));
		drain_and_settle();

		// Random phases, each with its own attribute; one of them runs flat out
		foreach (attr_plan[p]) begin
			write_attr(attr_plan[p]);
			quiet = (p == 2);
			repeat (48) pending_items.push_back(make_random_item());
			drain_and_settle();
		end

		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> integer_to_padded_text_top.f
+incdir+rtl
rtl/itpt_pkg.sv
rtl/itpt_ctrl.sv
rtl/itpt_datapath.sv
rtl/integer_to_padded_text_top.sv
sim/integer_to_padded_text_top_tb.sv
